FILE: src/bounded_stack_insert_find_assert.svh
// Assertion macros for the bounded stack block.
// Used by the top level; expects clk and rst_n in scope at the point of use.
`ifndef BOUNDED_STACK_INSERT_FIND_ASSERT_SVH
`define BOUNDED_STACK_INSERT_FIND_ASSERT_SVH

// check cons in the same cycle as ante
`define BSIF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// check cons in the cycle after ante
`define BSIF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/bsif_pkg.sv
// Shared types and codes for the bounded stack block.
// No dependencies; used by the controller, the datapath and the top level.
package bsif_pkg;

  localparam int MODE_W      = 3;
  localparam int POS_W       = 5;
  localparam int WORD_W      = 32;
  localparam int IDX_FIELD_W = 4;
  localparam int STATUS_W    = 3;
  localparam int CNT_FIELD_W = 5;

  localparam logic [MODE_W-1:0] MODE_PUSH   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_POP    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PEEK   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_INSERT = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FIND   = 3'd4;

  localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY     = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_BAD_POS   = 3'd4;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  position;
    logic [WORD_W-1:0] word;
  } in_t;

  typedef struct packed {
    logic [WORD_W-1:0]      read_word;
    logic [IDX_FIELD_W-1:0] found_index;
    logic [STATUS_W-1:0]    status;
    logic [CNT_FIELD_W-1:0] count;
  } out_t;

  typedef struct packed {
    logic exec;
    logic find_start;
    logic scan;
    logic find_done;
  } ctrl_cmd_t;

  typedef struct packed {
    logic empty;
    logic scan_hit;
    logic scan_last;
  } dp_stat_t;

endpackage

FILE: src/bsif_dp.sv
// Datapath: entry registers, fill count, find scan pointer and result register.
// Depends on bsif_pkg; driven by commands from bsif_ctrl.
module bsif_dp #(
  parameter int DEPTH      = 16,
  parameter int WORD_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bsif_pkg::ctrl_cmd_t cmd,
  input  bsif_pkg::in_t       in_data,
  output bsif_pkg::dp_stat_t  stat,
  output bsif_pkg::out_t      out_data
);

  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMP_W      = (CNT_W > bsif_pkg::POS_W) ? CNT_W : bsif_pkg::POS_W;
  localparam int OUT_WORD_W = bsif_pkg::WORD_W;
  localparam int OUT_IDX_W  = bsif_pkg::IDX_FIELD_W;
  localparam int OUT_CNT_W  = bsif_pkg::CNT_FIELD_W;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WORD_WIDTH-1:0] entries_r   [DEPTH];
  logic [WORD_WIDTH-1:0] entries_nxt [DEPTH];
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [WORD_WIDTH-1:0] key_r, key_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  bsif_pkg::out_t        out_r, out_nxt;

  logic                          full;
  logic                          empty;
  logic [IDX_W-1:0]              top_idx;
  logic [IDX_W-1:0]              rd_idx;
  logic [WORD_WIDTH-1:0]         rd_word;
  logic [WORD_WIDTH-1:0]         in_word;
  logic                          pos_bad;
  logic [IDX_W-1:0]              ins_pos;
  logic                          ins_en;
  logic [bsif_pkg::STATUS_W-1:0] status;
  logic [WORD_WIDTH-1:0]         rd;
  logic                          hit;

  always_comb begin
    full    = (count_r == FULL_CNT);
    empty   = (count_r == '0);
    top_idx = IDX_W'(count_r - 1'b1);
    rd_idx  = cmd.scan ? idx_r : top_idx;
    rd_word = entries_r[rd_idx];
    in_word = WORD_WIDTH'(in_data.word);
    pos_bad = (CMP_W'(in_data.position) > CMP_W'(count_r));
    ins_pos = (in_data.mode == bsif_pkg::MODE_PUSH) ? IDX_W'(count_r)
                                                   : IDX_W'(in_data.position);
    hit     = (rd_word == key_r);
  end

  assign stat.empty     = empty;
  assign stat.scan_hit  = hit;
  assign stat.scan_last = (CNT_W'(idx_r) == (count_r - 1'b1));

  always_comb begin
    entries_nxt = entries_r;
    count_nxt   = count_r;
    key_nxt     = key_r;
    idx_nxt     = idx_r;
    out_nxt     = out_r;
    ins_en      = 1'b0;
    status      = bsif_pkg::STAT_OK;
    rd          = '0;

    if (cmd.exec) begin
      case (in_data.mode)
        bsif_pkg::MODE_PUSH: begin
          if (full) begin
            status = bsif_pkg::STAT_FULL;
          end else begin
            ins_en = 1'b1;
          end
        end
        bsif_pkg::MODE_POP: begin
          if (empty) begin
            status = bsif_pkg::STAT_EMPTY;
          end else begin
            count_nxt = count_r - 1'b1;
            rd        = rd_word;
          end
        end
        bsif_pkg::MODE_PEEK: begin
          if (empty) begin
            status = bsif_pkg::STAT_EMPTY;
          end else begin
            rd = rd_word;
          end
        end
        bsif_pkg::MODE_INSERT: begin
          if (full) begin
            status = bsif_pkg::STAT_FULL;
          end else if (pos_bad) begin
            status = bsif_pkg::STAT_BAD_POS;
          end else begin
            ins_en = 1'b1;
          end
        end
        bsif_pkg::MODE_FIND: begin
          status = bsif_pkg::STAT_NOT_FOUND;
        end
        default: begin
          status = bsif_pkg::STAT_OK;
        end
      endcase

      if (ins_en) begin
        for (int i = 1; i < DEPTH; i++) begin
          if ((IDX_W'(i) > ins_pos) && (CNT_W'(i) <= count_r)) begin
            entries_nxt[i] = entries_r[i-1];
          end
        end
        entries_nxt[ins_pos] = in_word;
        count_nxt = count_r + 1'b1;
      end

      out_nxt.read_word   = OUT_WORD_W'(rd);
      out_nxt.found_index = '0;
      out_nxt.status      = status;
      out_nxt.count       = OUT_CNT_W'(count_nxt);
    end

    if (cmd.find_start) begin
      key_nxt = in_word;
      idx_nxt = '0;
    end

    if (cmd.scan && !cmd.find_done) begin
      idx_nxt = idx_r + 1'b1;
    end

    if (cmd.find_done) begin
      out_nxt.read_word   = '0;
      out_nxt.found_index = hit ? OUT_IDX_W'(idx_r) : '0;
      out_nxt.status      = hit ? bsif_pkg::STAT_OK : bsif_pkg::STAT_NOT_FOUND;
      out_nxt.count       = OUT_CNT_W'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entries_r <= entries_nxt;
    key_r     <= key_nxt;
    idx_r     <= idx_nxt;
    out_r     <= out_nxt;
  end

  assign out_data = out_r;

endmodule

FILE: src/bsif_ctrl.sv
// Controller: handshake control, find scan sequencing and result valid.
// Depends on bsif_pkg; commands bsif_dp.
module bsif_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic [bsif_pkg::MODE_W-1:0]     in_mode,
  input  logic                            out_ready,
  input  bsif_pkg::dp_stat_t              stat,
  output logic                            in_ready,
  output logic                            out_valid,
  output bsif_pkg::ctrl_cmd_t             cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   start_find;

  always_comb begin
    in_ready       = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
    accept         = in_valid && in_ready;
    start_find     = accept && (in_mode == bsif_pkg::MODE_FIND) && !stat.empty;
    cmd.exec       = accept && !start_find;
    cmd.find_start = start_find;
    cmd.scan       = (state_r == ST_SCAN);
    cmd.find_done  = cmd.scan && (stat.scan_hit || stat.scan_last);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start_find) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cmd.find_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.exec || cmd.find_done) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: src/bounded_stack_insert_find.sv
// Bounded stack of DEPTH words with push, pop, peek, insert-at-slot and find.
// Each request gives one result with the word read, found slot, status and
// count. Push, pop, peek, insert and unused modes give their result in the
// cycle after they are accepted; a new request is accepted each cycle while
// the result register is empty or being drained. Find on a non-empty stack
// scans one slot per cycle through the single entry read port, from slot 0 up
// to the lowest match (or the top slot if none); no request is accepted during
// the scan. Depends on bsif_pkg, bsif_ctrl and bsif_dp.
`include "bounded_stack_insert_find_assert.svh"

module bounded_stack_insert_find #(
  parameter int DEPTH      = 16,
  parameter int WORD_WIDTH = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  bsif_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output bsif_pkg::out_t out_data
);

  localparam int OUT_CNT_W = bsif_pkg::CNT_FIELD_W;
  localparam logic [OUT_CNT_W-1:0] FULL_FIELD = OUT_CNT_W'(DEPTH);

  bsif_pkg::ctrl_cmd_t cmd;
  bsif_pkg::dp_stat_t  stat;

  logic xfer_no_find;
  logic out_full;
  logic out_empty;
  logic full_ok;
  logic empty_ok;

  bsif_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_mode   (in_data.mode),
    .out_ready (out_ready),
    .stat      (stat),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  bsif_dp #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .stat     (stat),
    .out_data (out_data)
  );

  assign xfer_no_find = in_valid && in_ready && (in_data.mode != bsif_pkg::MODE_FIND);
  assign out_full     = out_valid && (out_data.status == bsif_pkg::STAT_FULL);
  assign out_empty    = out_valid && (out_data.status == bsif_pkg::STAT_EMPTY);
  assign full_ok      = (out_data.count == FULL_FIELD) && (out_data.read_word == '0);
  assign empty_ok     = (out_data.count == '0) && (out_data.read_word == '0);

  `BSIF_ASSERT_NEXT(a_single_cycle_result, xfer_no_find, out_valid, "non-find transfer lost")
  `BSIF_ASSERT_SAME(a_full_count, out_full, full_ok, "full status with wrong count")
  `BSIF_ASSERT_SAME(a_empty_count, out_empty, empty_ok, "empty status with entries held")

endmodule
